/* hw/rtl/esg_pkg.sv */
// Shared types, constants and helpers for the encoder-to-stepper gearing block.
package esg_pkg;

   // Fixed-point position of the gear ratio.
   localparam int FRAC_SHIFT  = 32;
   localparam int SCALE_SHIFT = FRAC_SHIFT - 16;

   localparam logic [31:0] MID_POSITION  = 32'h8000_0000;
   localparam logic [31:0] RESYNC_FLOOR  = 32'd10000;
   localparam logic [31:0] LAG_LIMIT     = 32'd255;
   localparam logic [15:0] JITTER_SPAN   = 16'd10;
   localparam logic [15:0] JITTER_NEG    = 16'hFFF6;   // -10 as a 16-bit count
   localparam logic [31:0] SEEN_RATIO_RST = 32'hFFFF_FFFF;

   // Fault codes.
   localparam logic [1:0] FAULT_NONE  = 2'd0;
   localparam logic [1:0] FAULT_LAG   = 2'd1;
   localparam logic [1:0] FAULT_ALARM = 2'd2;

   // Register indexes on the csr channel.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_GEAR_RATIO   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_REVERSE_MODE = 1'd1;

   typedef struct packed {
      logic [15:0] encoder_count;
      logic        servo_ready;
      logic        servo_alarm;
      logic        clear_fault;
   } req_type;

   typedef struct packed {
      logic       issue_steps;
      logic [7:0] step_count;
      logic       step_direction;
      logic [1:0] fault_code;
      logic       stop_servo;
   } rsp_type;

   typedef struct packed {
      logic [31:0] gear_ratio;
      logic        reverse_mode;
   } cfg_type;

   // Servo target for the mid-range spindle position: MID_POSITION * ratio, scaled.
   function automatic logic [31:0] mid_target(input logic [31:0] ratio);
      logic [63:0] prod;
      prod = 64'(ratio) << 31;
      return prod[SCALE_SHIFT +: 32];
   endfunction

endpackage

/* hw/rtl/esg_if.sv */
// Channel interfaces: request, response and csr write.
interface esg_req_if;
   logic             valid;
   logic             ready;
   esg_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface esg_rsp_if;
   logic             valid;
   logic             ready;
   esg_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface esg_csr_if;
   logic                             valid;
   logic                             ready;
   logic [esg_pkg::CSR_INDEX_W-1:0]  reg_index;
   logic [31:0]                      wdata;
   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

/* hw/rtl/esg_csr.sv */
// Configuration registers: gear ratio and reverse mode.
module esg_csr (
   input  logic             clock,
   input  logic             reset,
   esg_csr_if.sink          csr_chan,
   output esg_pkg::cfg_type cfg
);
   esg_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.reg_index)
            esg_pkg::REG_GEAR_RATIO:   cfg_in.gear_ratio   = csr_chan.wdata;
            esg_pkg::REG_REVERSE_MODE: cfg_in.reverse_mode = csr_chan.wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

/* hw/rtl/esg_track.sv */
// Tracking state and per-tick gearing datapath.
module esg_track (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  esg_pkg::req_type req,
   input  esg_pkg::cfg_type cfg,
   output esg_pkg::rsp_type rsp
);
   logic [15:0] prev_count_ff, prev_count_in;
   logic [15:0] prev_delta_ff, prev_delta_in;
   logic [31:0] spindle_ff, spindle_in;
   logic [31:0] servo_ff, servo_in;
   logic [31:0] seen_ratio_ff, seen_ratio_in;
   logic        seen_rev_ff, seen_rev_in;
   logic [1:0]  fault_ff, fault_in;

   logic [15:0] delta;
   logic        jitter;
   logic [1:0]  fault_base;
   logic [31:0] delta32;
   logic [31:0] spin_sum;
   logic        resync;
   logic [31:0] spin_new;
   logic [31:0] ratio_eff;
   logic [31:0] servo_base;
   logic [63:0] prod;
   logic [31:0] target;
   logic [31:0] diff;
   logic [31:0] mag;
   logic [1:0]  fault_new;
   logic        issue;

   always_comb begin
      delta      = req.encoder_count - prev_count_ff;
      jitter     = (delta[15] != prev_delta_ff[15]) &&
                   ((delta < esg_pkg::JITTER_SPAN) || (delta > esg_pkg::JITTER_NEG));
      fault_base = req.clear_fault ? esg_pkg::FAULT_NONE : fault_ff;
      delta32    = {{16{delta[15]}}, delta};
      spin_sum   = spindle_ff + delta32;
      resync     = (cfg.gear_ratio != seen_ratio_ff) || (cfg.reverse_mode != seen_rev_ff) ||
                   (spin_sum < esg_pkg::RESYNC_FLOOR);
      spin_new   = resync ? (esg_pkg::MID_POSITION + delta32) : spin_sum;
      ratio_eff  = resync ? cfg.gear_ratio : seen_ratio_ff;
      servo_base = resync ? esg_pkg::mid_target(cfg.gear_ratio) : servo_ff;
      prod       = 64'(spin_new) * 64'(ratio_eff);
      target     = prod[esg_pkg::SCALE_SHIFT +: 32];
      diff       = target - servo_base;
      mag        = diff[31] ? (32'd0 - diff) : diff;
      if (req.servo_alarm) begin
         fault_new = esg_pkg::FAULT_ALARM;
      end else if (mag > esg_pkg::LAG_LIMIT) begin
         fault_new = esg_pkg::FAULT_LAG;
      end else begin
         fault_new = fault_base;
      end
      issue = (fault_new == esg_pkg::FAULT_NONE) && (diff != 32'd0) && req.servo_ready;

      // Next state
      prev_count_in = prev_count_ff;
      prev_delta_in = prev_delta_ff;
      spindle_in    = spindle_ff;
      servo_in      = servo_ff;
      seen_ratio_in = seen_ratio_ff;
      seen_rev_in   = seen_rev_ff;
      fault_in      = fault_base;
      rsp           = '0;
      if (jitter) begin
         rsp.fault_code = fault_base;
         rsp.stop_servo = (fault_base != esg_pkg::FAULT_NONE);
      end else begin
         prev_count_in = req.encoder_count;
         prev_delta_in = delta;
         spindle_in    = spin_new;
         seen_rev_in   = resync ? cfg.reverse_mode : seen_rev_ff;
         seen_ratio_in = (fault_new == esg_pkg::FAULT_NONE) ? ratio_eff : 32'd0;
         servo_in      = issue ? target : servo_base;
         fault_in      = fault_new;
         rsp.issue_steps    = issue;
         rsp.step_count     = issue ? mag[7:0] : 8'd0;
         rsp.step_direction = issue & (diff[31] ^ cfg.reverse_mode);
         rsp.fault_code     = fault_new;
         rsp.stop_servo     = (fault_new != esg_pkg::FAULT_NONE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_count_ff <= '0;
         prev_delta_ff <= '0;
         spindle_ff    <= esg_pkg::MID_POSITION;
         servo_ff      <= esg_pkg::MID_POSITION;
         seen_ratio_ff <= esg_pkg::SEEN_RATIO_RST;
         seen_rev_ff   <= 1'b0;
         fault_ff      <= esg_pkg::FAULT_NONE;
      end else if (step_en) begin
         prev_count_ff <= prev_count_in;
         prev_delta_ff <= prev_delta_in;
         spindle_ff    <= spindle_in;
         servo_ff      <= servo_in;
         seen_ratio_ff <= seen_ratio_in;
         seen_rev_ff   <= seen_rev_in;
         fault_ff      <= fault_in;
      end
   end

   // A latched fault always forces the tracked ratio to zero.
   assert property (@(posedge clock) disable iff (reset)
      (fault_ff != esg_pkg::FAULT_NONE) |-> (seen_ratio_ff == 32'd0))
      else $error("faulted with nonzero seen ratio");

   // A burst leaves the servo position exactly on target.
   assert property (@(posedge clock) disable iff (reset)
      (step_en && issue && !jitter) |=> (servo_ff == $past(target)))
      else $error("servo position missed target after burst");

   // Jitter ticks leave the encoder history alone.
   assert property (@(posedge clock) disable iff (reset)
      (step_en && jitter) |=> $stable(prev_count_ff) && $stable(spindle_ff))
      else $error("jitter tick changed tracking state");
endmodule

/* hw/rtl/encoder_to_stepper_gearing_top.sv */
// Top level of the encoder-to-stepper gearing block.
//
//  channel  | dir | payload fields (each moves on valid & ready)
//  ---------+-----+----------------------------------------------------------------
//  req_chan | in  | encoder_count, servo_ready, servo_alarm, clear_fault
//  rsp_chan | out | issue_steps, step_count, step_direction, fault_code, stop_servo
//  csr_chan | in  | reg_index (0 gear_ratio, 1 reverse_mode), wdata
//
// One request in, one response out, one transfer per cycle sustained while the response side is not stalled.
// The request is registered, then the gearing tick
// (one 32x32 multiply plus the state update) runs into the response register.
// The state update loop (spindle add, ratio multiply, lag compare) is combinational between state registers.
// Reset is synchronous, active high; it restores the tracking state and config.
// A stalled response holds the request register; req ready drops only while both are full.
module encoder_to_stepper_gearing_top (
   input  logic      clock,
   input  logic      reset,
   esg_req_if.sink   req_chan,
   esg_rsp_if.source rsp_chan,
   esg_csr_if.sink   csr_chan
);
   esg_pkg::cfg_type cfg;
   esg_pkg::rsp_type tick_rsp;

   logic             in_valid_ff, in_valid_in;
   esg_pkg::req_type in_data_ff, in_data_in;
   logic             out_valid_ff, out_valid_in;
   esg_pkg::rsp_type out_data_ff, out_data_in;

   logic advance;   // response register can take a new result
   logic fire;      // tick runs on the held request this cycle

   assign advance = !out_valid_ff || rsp_chan.ready;
   assign fire    = in_valid_ff && advance;

   assign req_chan.ready = !in_valid_ff || advance;

   esg_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   esg_track u_track (
      .clock   (clock),
      .reset   (reset),
      .step_en (fire),
      .req     (in_data_ff),
      .cfg     (cfg),
      .rsp     (tick_rsp)
   );

   always_comb begin
      // Request stage: refills whenever it empties or its item moves on.
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         in_data_in  = req_chan.data;
      end

      // Response stage: loads on a tick, clears once taken.
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (fire) begin
         out_valid_in = 1'b1;
         out_data_in  = tick_rsp;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_data_ff;

   // A held request is not dropped while the response side stalls.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("held request lost during stall");

   // Bursts only go out with no fault latched.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.data.issue_steps) |->
      (rsp_chan.data.fault_code == esg_pkg::FAULT_NONE))
      else $error("burst issued while faulted");

   // Stop follows the fault code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
      (rsp_chan.data.stop_servo == (rsp_chan.data.fault_code != esg_pkg::FAULT_NONE)))
      else $error("stop_servo disagrees with fault code");

   // A tick always produces a response in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("tick result not registered");
endmodule
